// ----- rtl/esbk_pkg.sv -----
// Package: record type, sequencer states and emit control for the exchange sort block.
`default_nettype none
package esbk_pkg;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_RD,
    ST_PASS_FIRST,
    ST_SCAN,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_HOLD
  } sort_state_t;

  typedef struct packed {
    logic load;
    logic last;
    logic dropped;
  } emit_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/esbk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module esbk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/esbk_sorter.sv -----
// Load, interchange-sort and read-out sequencer working on the record RAM.
`default_nettype none
module esbk_sorter
  import esbk_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [15:0]                 sort_key,
  input  wire logic [15:0]                 payload_tag,
  input  wire logic                        final_record,
  output logic                             ram_we,
  output logic      [$clog2(CAPACITY)-1:0] ram_waddr,
  output rec_t                             ram_wdata,
  output logic      [$clog2(CAPACITY)-1:0] ram_raddr,
  input  wire rec_t                        ram_rdata,
  output emit_ctl_t                        emit,
  input  wire logic                        out_take
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  sort_state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] n, n_next;
  logic             dropped, dropped_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] k, k_next;
  rec_t             cur, cur_next;

  logic full;
  logic accept;
  logic j_last;
  logic i_last;
  logic k_last;

  assign in_stall = (state != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(CAPACITY));
  assign j_last   = (CNT_W'(j) + CNT_W'(1)) == n;
  assign i_last   = (CNT_W'(i) + CNT_W'(2)) == n;
  assign k_last   = (CNT_W'(k) + CNT_W'(1)) == n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    n   <= n_next;
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    cur <= cur_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    n_next       = n;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    cur_next     = cur;
    ram_we       = 1'b0;
    ram_waddr    = i;
    ram_wdata    = cur;
    ram_raddr    = j + IDX_W'(1);
    emit         = '0;

    unique case (state)
      ST_LOAD: begin
        if (accept) begin
          if (!full) begin
            ram_we     = 1'b1;
            ram_waddr  = count[IDX_W-1:0];
            ram_wdata  = '{key: sort_key, tag: payload_tag};
            count_next = count + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (final_record) begin
            n_next = full ? count : count + CNT_W'(1);
            i_next = '0;
            k_next = '0;
            if (n_next >= CNT_W'(2)) begin
              state_next = ST_PASS_RD;
            end else begin
              state_next = ST_EMIT_RD;
            end
          end
        end
      end
      ST_PASS_RD: begin
        ram_raddr  = i;
        state_next = ST_PASS_FIRST;
      end
      ST_PASS_FIRST: begin
        // the candidate for entry i is held in cur for the whole pass
        cur_next   = ram_rdata;
        ram_raddr  = i + IDX_W'(1);
        j_next     = i + IDX_W'(1);
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        // read of j+1 overlaps write of j: never the same entry
        if (cur.key > ram_rdata.key) begin
          ram_we    = 1'b1;
          ram_waddr = j;
          ram_wdata = cur;
          cur_next  = ram_rdata;
        end
        if (j_last) begin
          state_next = ST_PASS_END;
        end else begin
          j_next = j + IDX_W'(1);
        end
      end
      ST_PASS_END: begin
        ram_we    = 1'b1;
        ram_waddr = i;
        ram_wdata = cur;
        if (i_last) begin
          k_next     = '0;
          state_next = ST_EMIT_RD;
        end else begin
          i_next     = i + IDX_W'(1);
          state_next = ST_PASS_RD;
        end
      end
      ST_EMIT_RD: begin
        ram_raddr  = k;
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        emit.load    = 1'b1;
        emit.last    = k_last;
        emit.dropped = dropped;
        state_next   = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_take) begin
          if (k_last) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = ST_LOAD;
          end else begin
            k_next     = k + IDX_W'(1);
            ram_raddr  = k + IDX_W'(1);
            state_next = ST_EMIT_WAIT;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/exchange_sort_by_key.sv -----
// A set of n records is loaded at one request a cycle while in_stall is low,
// sorted in passes that each read entry i, scan the later entries (one compare per cycle,
// RAM read-modify-write) and write entry i back, then read out one record at a time,
// the next only once the output has taken the last. No new set is taken until read-out ends.
// Reset clears the record count, the drop flag, the sequencer and output valid;
// RAM contents are undefined until written and need no clearing pass.
`default_nettype none
module exchange_sort_by_key
  import esbk_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] sort_key,
  input  wire logic [15:0] payload_tag,
  input  wire logic        final_record,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] sorted_key,
  output logic      [15:0] sorted_tag,
  output logic             end_of_run,
  output logic             capacity_exceeded
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  rec_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  rec_t             ram_rdata;
  emit_ctl_t        emit;
  logic             out_take;

  assign out_take = out_valid && !out_stall;

  esbk_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  esbk_sorter #(
    .CAPACITY (CAPACITY)
  ) u_sorter (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sort_key     (sort_key),
    .payload_tag  (payload_tag),
    .final_record (final_record),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .emit         (emit),
    .out_take     (out_take)
  );

  // output register: loaded only while empty, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      sorted_key        <= ram_rdata.key;
      sorted_tag        <= ram_rdata.tag;
      end_of_run        <= emit.last;
      capacity_exceeded <= emit.dropped;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/exchange_sort_by_key_tb.sv -----
// Testbench for exchange_sort_by_key: directed and random record sets checked against a sort model.
`timescale 1ns / 100ps
module exchange_sort_by_key_tb;
  import esbk_pkg::*;

  localparam int unsigned SET_CAPACITY = 64;
  localparam int unsigned STALL_LIMIT = 20000;  // cycles with no request moving
  localparam int unsigned RANDOM_RECORD_GOAL = 410;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
    logic        last;
    logic        dropped;
  } sorted_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] sort_key = '0;
  logic [15:0] payload_tag = '0;
  logic        final_record = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] sorted_key;
  logic [15:0] sorted_tag;
  logic        end_of_run;
  logic        capacity_exceeded;

  // model state: the set being loaded and the sorted records still to come out
  rec_t        loading_set[$];
  bit          loading_dropped = 1'b0;
  sorted_rec_t sorted_pending[$];
  sorted_rec_t next_sorted;

  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int          rx_hold_cycles = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned records_sent = 0;
  int unsigned sets_closed = 0;
  int unsigned overflow_sets = 0;
  int unsigned results_checked = 0;

  exchange_sort_by_key #(.CAPACITY(SET_CAPACITY)) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sort_key         (sort_key),
    .payload_tag      (payload_tag),
    .final_record     (final_record),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sorted_key       (sorted_key),
    .sorted_tag       (sorted_tag),
    .end_of_run       (end_of_run),
    .capacity_exceeded(capacity_exceeded)
  );

  always #5 clk = ~clk;

  // Store or drop (when full) an accepted record; on the last, exchange-sort and queue output
  function automatic void predict_sort(input rec_t rec, input logic last_v);
    rec_t        work[$];
    rec_t        swap_tmp;
    sorted_rec_t out_rec;
    int          n;
    if (loading_set.size() < SET_CAPACITY) begin
      loading_set.push_back(rec);
    end else begin
      loading_dropped = 1'b1;
    end
    if (!last_v) return;
    work = loading_set;
    n = work.size();
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (work[i].key > work[j].key) begin
          swap_tmp = work[i];
          work[i]  = work[j];
          work[j]  = swap_tmp;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      out_rec.key     = work[k].key;
      out_rec.tag     = work[k].tag;
      out_rec.last    = (k == n - 1);
      out_rec.dropped = loading_dropped;
      sorted_pending.push_back(out_rec);
    end
    sets_closed++;
    if (loading_dropped) overflow_sets++;
    loading_set.delete();
    loading_dropped = 1'b0;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_record(input logic [15:0] key_v, input logic [15:0] tag_v,
                             input logic last_v);
    rec_t rec;
    while (tx_gaps_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    sort_key     <= key_v;
    payload_tag  <= tag_v;
    final_record <= last_v;
    do @(posedge clk); while (in_stall);
    rec.key = key_v;
    rec.tag = tag_v;
    predict_sort(rec, last_v);
    records_sent++;
  endtask

  // Narrow key range now and then so that equal keys meet in the sort
  function automatic logic [15:0] pick_key();
    if ($urandom_range(2) == 0) return 16'($urandom_range(7));
    return 16'($urandom);
  endfunction

  task automatic send_set(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      send_record(pick_key(), 16'($urandom), k == count - 1);
    end
  endtask

  // Always waits on a clock edge, so valid is never lowered and raised in one step
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sorted_pending.size() != 0);
  endtask

  task automatic test_single_record();
    send_record(16'hFFFF, 16'h0000, 1'b1);
    send_record(16'h0000, 16'hFFFF, 1'b1);
  endtask

  task automatic test_extremes_and_ties();
    send_record(16'hFFFF, 16'h0001, 1'b0);
    send_record(16'h0000, 16'hFFFF, 1'b0);
    send_record(16'h8000, 16'h1234, 1'b0);
    send_record(16'h7FFF, 16'hAAAA, 1'b0);
    send_record(16'h0005, 16'h0001, 1'b0);
    send_record(16'h0005, 16'h0002, 1'b0);
    send_record(16'h0005, 16'h0003, 1'b0);
    send_record(16'h0001, 16'h5555, 1'b1);
    // already descending
    send_record(16'h0003, 16'h0030, 1'b0);
    send_record(16'h0002, 16'h0020, 1'b0);
    send_record(16'h0001, 16'h0010, 1'b1);
    wait_for_drain();
  endtask

  // Full store without a drop, then a set whose tail and final request are dropped
  task automatic test_store_full();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_set(SET_CAPACITY);
    send_set(SET_CAPACITY + 2);
    wait_for_drain();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Receiver holds off while sets keep coming, so the input side backs up
  task automatic test_output_backpressure();
    rx_hold_cycles = 600;
    send_set(12);
    send_set(12);
    send_set(5);
    wait_for_drain();
  endtask

  task automatic test_random_sets();
    int unsigned set_len;
    while (records_sent < RANDOM_RECORD_GOAL) begin
      if ($urandom_range(11) == 0) begin
        set_len = $urandom_range(SET_CAPACITY + 6, 40);
      end else begin
        set_len = $urandom_range(12, 1);
      end
      send_set(set_len);
      if ($urandom_range(3) == 0) wait_for_drain();
    end
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_stall <= 1'b1;
      rx_hold_cycles--;
    end else begin
      out_stall <= rx_gaps_on && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sorted_pending.size() == 0) begin
        $error("unexpected result: sorted_key %h sorted_tag %h", sorted_key, sorted_tag);
        mismatch_count++;
      end else begin
        next_sorted = sorted_pending.pop_front();
        results_checked++;
        if (sorted_key !== next_sorted.key) begin
          $error("sorted_key: expected %h, got %h", next_sorted.key, sorted_key);
          mismatch_count++;
        end
        if (sorted_tag !== next_sorted.tag) begin
          $error("sorted_tag: expected %h, got %h", next_sorted.tag, sorted_tag);
          mismatch_count++;
        end
        if (end_of_run !== next_sorted.last) begin
          $error("end_of_run: expected %b, got %b", next_sorted.last, end_of_run);
          mismatch_count++;
        end
        if (capacity_exceeded !== next_sorted.dropped) begin
          $error("capacity_exceeded: expected %b, got %b", next_sorted.dropped,
                 capacity_exceeded);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("timeout: no request moved for %0d cycles, %0d results outstanding",
               idle_cycles, sorted_pending.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_record();
    test_extremes_and_ties();
    test_store_full();
    test_output_backpressure();
    test_random_sets();
    repeat (40) @(posedge clk);
    $display("Covered %0d records in %0d sets, %0d of them over capacity.",
             records_sent, sets_closed, overflow_sets);
    $display("Checked %0d sorted records, incl. ties, single-record sets and a long output stall.",
             results_checked);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/esbk_pkg.sv
rtl/esbk_ram.sv
rtl/esbk_sorter.sv
rtl/exchange_sort_by_key.sv
tb/sv/exchange_sort_by_key_tb.sv
